// File: design/signal_step_position_tracker_macros.svh
// Assertion helpers for the step position tracker.
// All checks run on clk_i and are off while rst_ni is low.
`ifndef SIGNAL_STEP_POSITION_TRACKER_MACROS_SVH
`define SIGNAL_STEP_POSITION_TRACKER_MACROS_SVH

// Same-cycle implication.
`define SSPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sspt_pkg.sv
`default_nettype none

package sspt_pkg;

  localparam int unsigned MaxStepsDef = 16;
  localparam int unsigned PosMax      = 131071;
  localparam int unsigned CfgAddrW    = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CYCLE_TOTAL = 2'd0,
    CFG_STEP_COUNT  = 2'd1
  } cfg_addr_e;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               func;
    logic [3:0]         entry_index;
    logic [15:0]        step_duration;
    logic [15:0]        step_countdown;
    logic [2:0]         step_color;
    logic signed [15:0] advance;
  } in_t;

  typedef struct packed {
    logic [3:0]  step_index;
    logic [2:0]  color;
    logic [15:0] time_left;
    logic [15:0] countdown_now;
    logic [16:0] position;
  } out_t;

  // One table entry as kept in the step memory.
  typedef struct packed {
    logic [15:0] dur;
    logic [15:0] cd;
    logic [2:0]  color;
  } entry_t;

  typedef struct packed {
    logic mem_wr;
    logic pos_upd;
    logic scan_clr;
    logic scan_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic hit;
    logic exhausted;
  } sts_t;

endpackage

`default_nettype wire

// File: design/sspt_ctrl.sv
`default_nettype none

module sspt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          func_i,
  input  sspt_pkg::sts_t     sts_i,
  output sspt_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  sspt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sspt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      sspt_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (func_i == sspt_pkg::FUNC_ADVANCE) begin
            if (sts_i.n_zero) begin
              // empty table: keep position, repeat last result
              state_d = sspt_pkg::ST_FIN;
            end else begin
              cmd_o.pos_upd  = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d        = sspt_pkg::ST_SCAN;
            end
          end else begin
            cmd_o.mem_wr = 1'b1;
          end
        end
      end
      sspt_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.exhausted) begin
          state_d = sspt_pkg::ST_FIN;
        end
      end
      sspt_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = sspt_pkg::ST_IDLE;
      end
      default: begin
        state_d = sspt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/sspt_datapath.sv
`default_nettype none

module sspt_datapath #(
  parameter int unsigned MAX_STEPS = sspt_pkg::MaxStepsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  sspt_pkg::in_t                        item_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [sspt_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [15:0]                     cfg_data_i,
  input  sspt_pkg::cmd_t                       cmd_i,
  output sspt_pkg::sts_t                       sts_o,
  output logic                                 done_o,
  output sspt_pkg::out_t                       result_o
);

  localparam int unsigned IdxW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);
  localparam int unsigned SumW = 16 + CntW;
  localparam int unsigned CmpW = (SumW > 17) ? SumW : 17;

  // configuration
  logic [15:0] cycle_total_q;
  logic [4:0]  step_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_total_q <= '0;
      step_count_q  <= '0;
    end else if (cfg_valid_i) begin
      case (sspt_pkg::cfg_addr_e'(cfg_addr_i))
        sspt_pkg::CFG_CYCLE_TOTAL: cycle_total_q <= cfg_data_i;
        sspt_pkg::CFG_STEP_COUNT:  step_count_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective entry count, clamped to the table depth
  logic [CntW-1:0] n_lim;
  always_comb begin
    if ({27'd0, step_count_q} > MAX_STEPS) begin
      n_lim = CntW'(MAX_STEPS);
    end else begin
      n_lim = CntW'(step_count_q);
    end
  end

  // position update: add delta, wrap once, saturate, floor at zero
  logic [16:0]        pos_q;
  logic [16:0]        pos_new;
  logic signed [18:0] pos_sum;
  logic signed [18:0] pos_wrap;

  always_comb begin
    pos_sum  = $signed({2'b00, pos_q}) + $signed({{3{item_i.advance[15]}}, item_i.advance});
    pos_wrap = pos_sum - $signed({3'b000, cycle_total_q});
    if (!pos_wrap[18]) begin
      if (pos_wrap > $signed(19'(sspt_pkg::PosMax))) begin
        pos_new = 17'(sspt_pkg::PosMax);
      end else begin
        pos_new = pos_wrap[16:0];
      end
    end else if (pos_sum[18]) begin
      pos_new = '0;
    end else begin
      pos_new = pos_sum[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.pos_upd) begin
      pos_q <= pos_new;
    end
  end

  // step table
  sspt_pkg::entry_t mem_q [MAX_STEPS];
  sspt_pkg::entry_t rdata_q;
  logic [CntW-1:0]  ra_q;
  logic             wr_ok;
  logic             issue_ok;

  assign wr_ok    = cmd_i.mem_wr && ({28'd0, item_i.entry_index} < MAX_STEPS);
  assign issue_ok = ra_q < n_lim;

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[IdxW'(item_i.entry_index)] <= '{dur:   item_i.step_duration,
                                            cd:    item_i.step_countdown,
                                            color: item_i.step_color};
    end
    rdata_q <= mem_q[ra_q[IdxW-1:0]];
  end

  // scan: issue stage (ra_q) and accumulate stage (rd_vld_q)
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [SumW-1:0]   sum_q;
  logic [SumW-1:0]   sum_d;
  logic              hit;
  logic              hit_q;
  logic [15:0]       hit_sum_q;
  logic [IdxW-1:0]   hit_idx_q;
  sspt_pkg::entry_t  hit_ent_q;

  assign sum_d = sum_q + SumW'(rdata_q.dur);
  assign hit   = cmd_i.scan_step && rd_vld_q && (CmpW'(sum_d) > CmpW'(pos_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q     <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      ra_q     <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (issue_ok) begin
        ra_q <= ra_q + CntW'(1);
      end
      rd_vld_q <= issue_ok && !hit;
      if (hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      sum_q <= '0;
    end else if (cmd_i.scan_step && rd_vld_q) begin
      sum_q <= sum_d;
    end
    if (cmd_i.scan_step) begin
      rd_idx_q <= ra_q[IdxW-1:0];
    end
    if (hit) begin
      hit_sum_q <= sum_d[15:0];
      hit_idx_q <= rd_idx_q;
      hit_ent_q <= rdata_q;
    end
  end

  assign sts_o.n_zero    = (n_lim == '0);
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = !rd_vld_q && !issue_ok;

  // result: time left and countdown less elapsed, all mod 2^16
  logic [15:0] left_new;
  logic [15:0] count_new;
  logic [3:0]  last_idx_q;
  logic [2:0]  last_color_q;
  logic [15:0] last_left_q;
  logic [15:0] last_count_q;
  logic        done_q;

  assign left_new  = hit_sum_q - pos_q[15:0];
  assign count_new = hit_ent_q.cd - hit_ent_q.dur + left_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q   <= '0;
      last_color_q <= '0;
      last_left_q  <= '0;
      last_count_q <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
      if (cmd_i.fin && hit_q) begin
        last_idx_q   <= 4'(hit_idx_q);
        last_color_q <= hit_ent_q.color;
        last_left_q  <= left_new;
        last_count_q <= count_new;
      end
    end
  end

  assign done_o                 = done_q;
  assign result_o.step_index    = last_idx_q;
  assign result_o.color         = last_color_q;
  assign result_o.time_left     = last_left_q;
  assign result_o.countdown_now = last_count_q;
  assign result_o.position      = pos_q;

endmodule

`default_nettype wire

// File: design/signal_step_position_tracker.sv
// Signal step position tracker. A word on item_i is taken at a rising edge
// with start high and busy low. A load word (func = 0) writes one step entry
// and gives no result. An advance word moves the cycle position and scans
// the step table one entry per cycle, since the table is a single-read-port
// memory; the scan stops at the first step that holds the position or after
// step_count entries (step_count clamped to MAX_STEPS), and an empty table
// skips the scan and repeats the last result. done_o is then high for
// exactly one cycle with the result word on result_o. The receiver cannot
// stall: result_o and done_o are registers and the word must be taken in
// that cycle. busy is low again in the done_o cycle, so a new word may start
// there. Configuration writes (cycle_total at index 0, step_count at
// index 1) are always taken and are meant for idle periods only.
`default_nettype none

`include "signal_step_position_tracker_macros.svh"

module signal_step_position_tracker #(
  parameter int unsigned MAX_STEPS = sspt_pkg::MaxStepsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  sspt_pkg::in_t                        item_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sspt_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [15:0]                     cfg_data_i,
  output logic                                 done_o,
  output sspt_pkg::out_t                       result_o
);

  sspt_pkg::cmd_t cmd;
  sspt_pkg::sts_t sts;
  logic           cfg_we;

  // config registers take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer: idle / scan / finish
  sspt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (item_i.func),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // position, step table, scan accumulator, result registers
  sspt_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_valid_i (cfg_we),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // done word is only shown while the sequencer is back in idle
  `SSPT_ASSERT_NOW(a_done_idle, done_o, !busy, "done while busy")
  // strobe lasts one cycle
  `SSPT_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "done held two cycles")
  // an advance always occupies the block
  `SSPT_ASSERT_NEXT(a_adv_busy, start && !busy && (item_i.func == sspt_pkg::FUNC_ADVANCE), busy, "advance not taken")
  // a load never yields a result
  `SSPT_ASSERT_NEXT(a_load_quiet, start && !busy && (item_i.func == sspt_pkg::FUNC_LOAD), !done_o && !busy, "load produced a result")

endmodule

`default_nettype wire
